// ===== hdl/breathing_ring_overlay_blend_unit_macros.svh =====
// Assertion macros shared by the checker.
`ifndef BREATHING_RING_OVERLAY_BLEND_UNIT_MACROS_SVH
`define BREATHING_RING_OVERLAY_BLEND_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define BROB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define BROB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/brob_pkg.sv =====
// Types and constants of the breathing ring overlay blend unit.
`timescale 1ns / 1ps

package brob_pkg;

   typedef struct packed {
      logic [7:0]  column;
      logic [7:0]  row;
      logic [15:0] under_pixel;
      logic [15:0] elapsed_ms;
   } req_payload_type;

   typedef struct packed {
      logic        in_ring;
      logic [15:0] out_pixel;
      logic [7:0]  ring_alpha;
   } rsp_payload_type;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALERT_COLOR = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RING_ACTIVE = 1'd1;

   localparam int RING_THICKNESS = 3;

   localparam logic [15:0] PULSE_MS    = 16'd1000;
   localparam logic [15:0] FINAL_START = 16'd2000;
   localparam logic [15:0] HOLD_START  = 16'd2500;
   localparam logic [9:0]  FADE_MS     = 10'd500;
   localparam logic [9:0]  PULSE_MS_10 = 10'd1000;

   // floor(m / 125) = (m * ALPHA_RECIP) >> ALPHA_SHIFT for all m below 2^15
   localparam logic [15:0] ALPHA_RECIP = 16'd33555;
   localparam int          ALPHA_SHIFT = 22;

   typedef enum logic [1:0] {
      PHASE_PULSE = 2'd0,
      PHASE_FINAL = 2'd1,
      PHASE_HOLD  = 2'd2
   } phase_type;

endpackage

// ===== hdl/breathing_ring_overlay_blend_unit.sv =====
// Breathing ring overlay blend unit: seven-stage pixel pipeline.
`timescale 1ns / 1ps

// Blends a pulsing alert ring over an RGB565 pixel stream. One pixel enters per clock while
// req_stall is low; the pipeline is seven register stages (position and timeline phase,
// squares and ramp, ring test and alpha numerator, reciprocal multiply, alpha, channel
// products, divide by 255 and pack), each with its own valid bit, so bubbles collapse and
// rsp_stall holds only the stages that are full. alert_color and ring_active are written
// through the csr port, which is always ready; write them only while no pixel
// is in flight.
module breathing_ring_overlay_blend_unit #(
   parameter int SCREEN_WIDTH  = 240,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  brob_pkg::req_payload_type     req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output brob_pkg::rsp_payload_type     rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [brob_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                   csr_wdata
);

   localparam int STAGES = 7;
   localparam int CX     = SCREEN_WIDTH / 2;
   localparam int CY     = SCREEN_HEIGHT / 2;
   localparam int R_OUT  = SCREEN_WIDTH / 2 - 1;
   localparam int R_IN   = R_OUT - brob_pkg::RING_THICKNESS;
   localparam logic [17:0] ROUT_SQ = 18'(R_OUT * R_OUT);
   localparam logic [17:0] RIN_SQ  = 18'(R_IN * R_IN);

   typedef struct packed {
      logic signed [8:0]   dx;
      logic signed [8:0]   dy;
      logic                on_screen;
      logic [9:0]          phase_ms;
      brob_pkg::phase_type phase;
      logic [15:0]         under;
   } s1_type;

   typedef struct packed {
      logic [16:0] sq_x;
      logic [16:0] sq_y;
      logic        on_screen;
      logic [8:0]  ramp;
      logic [15:0] under;
   } s2_type;

   typedef struct packed {
      logic        ring;
      logic [14:0] numer;
      logic        alpha_zero;
      logic        alpha_full;
      logic [15:0] under;
   } s3_type;

   typedef struct packed {
      logic        ring;
      logic [30:0] prod;
      logic        alpha_zero;
      logic        alpha_full;
      logic [15:0] under;
   } s4_type;

   typedef struct packed {
      logic        ring;
      logic [7:0]  alpha;
      logic [15:0] under;
   } s5_type;

   typedef struct packed {
      logic        ring;
      logic [7:0]  alpha;
      logic [15:0] sum_r;
      logic [15:0] sum_g;
      logic [15:0] sum_b;
      logic [15:0] under;
   } s6_type;

   logic [15:0]            alert_color_ff, alert_color_in;
   logic                   ring_active_ff, ring_active_in;
   logic                   active;
   logic [STAGES-1:0]      vld_ff, vld_in;
   logic [STAGES:0]        rdy;
   s1_type                 s1_ff, s1_in;
   s2_type                 s2_ff, s2_in;
   s3_type                 s3_ff, s3_in;
   s4_type                 s4_ff, s4_in;
   s5_type                 s5_ff, s5_in;
   s6_type                 s6_ff, s6_in;
   brob_pkg::rsp_payload_type s7_ff, s7_in;

   assign csr_ready = 1'b1;
   assign active    = ring_active_ff && (alert_color_ff != 16'd0);

   always_comb begin
      alert_color_in = alert_color_ff;
      ring_active_in = ring_active_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            brob_pkg::CSR_ALERT_COLOR: alert_color_in = csr_wdata;
            brob_pkg::CSR_RING_ACTIVE: ring_active_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alert_color_ff <= 16'd0;
         ring_active_ff <= 1'b0;
      end else begin
         alert_color_ff <= alert_color_in;
         ring_active_ff <= ring_active_in;
      end
   end

   always_comb begin
      rdy[STAGES] = !rsp_stall;
      for (int k = STAGES - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   always_comb begin
      if (rdy[0]) begin
         vld_in[0] = req_valid;
      end else begin
         vld_in[0] = vld_ff[0];
      end
      for (int k = 1; k < STAGES; k++) begin
         if (rdy[k]) begin
            vld_in[k] = vld_ff[k-1];
         end else begin
            vld_in[k] = vld_ff[k];
         end
      end
   end

   assign req_stall   = !rdy[0];
   assign rsp_valid   = vld_ff[STAGES-1];
   assign rsp_payload = s7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      s1_in.dx        = 9'({1'b0, req_payload.column} - 9'(CX));
      s1_in.dy        = 9'({1'b0, req_payload.row} - 9'(CY));
      s1_in.on_screen = ({1'b0, req_payload.column} < 9'(SCREEN_WIDTH))
                     && ({1'b0, req_payload.row} < 9'(SCREEN_HEIGHT));
      s1_in.under     = req_payload.under_pixel;
      if (req_payload.elapsed_ms >= brob_pkg::HOLD_START) begin
         s1_in.phase    = brob_pkg::PHASE_HOLD;
         s1_in.phase_ms = 10'd0;
      end else if (req_payload.elapsed_ms >= brob_pkg::FINAL_START) begin
         s1_in.phase    = brob_pkg::PHASE_FINAL;
         s1_in.phase_ms = 10'(req_payload.elapsed_ms - brob_pkg::FINAL_START);
      end else if (req_payload.elapsed_ms >= brob_pkg::PULSE_MS) begin
         s1_in.phase    = brob_pkg::PHASE_PULSE;
         s1_in.phase_ms = 10'(req_payload.elapsed_ms - brob_pkg::PULSE_MS);
      end else begin
         s1_in.phase    = brob_pkg::PHASE_PULSE;
         s1_in.phase_ms = 10'(req_payload.elapsed_ms);
      end
   end

   always_comb begin
      logic signed [17:0] px;
      logic signed [17:0] py;
      px = s1_ff.dx * s1_ff.dx;
      py = s1_ff.dy * s1_ff.dy;
      s2_in.sq_x      = 17'(px);
      s2_in.sq_y      = 17'(py);
      s2_in.on_screen = s1_ff.on_screen;
      s2_in.under     = s1_ff.under;
      case (s1_ff.phase)
         brob_pkg::PHASE_PULSE: begin
            if (s1_ff.phase_ms < brob_pkg::FADE_MS) begin
               s2_in.ramp = 9'(s1_ff.phase_ms);
            end else begin
               s2_in.ramp = 9'(brob_pkg::PULSE_MS_10 - s1_ff.phase_ms);
            end
         end
         brob_pkg::PHASE_FINAL: s2_in.ramp = 9'(s1_ff.phase_ms);
         default:               s2_in.ramp = 9'(brob_pkg::FADE_MS);
      endcase
   end

   always_comb begin
      logic [17:0] d2;
      logic [16:0] numer_full;
      d2               = {1'b0, s2_ff.sq_x} + {1'b0, s2_ff.sq_y};
      numer_full       = ({s2_ff.ramp, 8'd0} - {8'd0, s2_ff.ramp}) + 17'd250;
      s3_in.ring       = s2_ff.on_screen && (d2 <= ROUT_SQ) && (d2 >= RIN_SQ);
      s3_in.numer      = numer_full[16:2];
      s3_in.alpha_zero = s2_ff.ramp <= 9'd1;
      s3_in.alpha_full = s2_ff.ramp >= 9'(brob_pkg::FADE_MS);
      s3_in.under      = s2_ff.under;
   end

   always_comb begin
      s4_in.ring       = s3_ff.ring;
      s4_in.prod       = {16'd0, s3_ff.numer} * {15'd0, brob_pkg::ALPHA_RECIP};
      s4_in.alpha_zero = s3_ff.alpha_zero;
      s4_in.alpha_full = s3_ff.alpha_full;
      s4_in.under      = s3_ff.under;
   end

   always_comb begin
      s5_in.ring  = s4_ff.ring;
      s5_in.under = s4_ff.under;
      if (!active || s4_ff.alpha_zero) begin
         s5_in.alpha = 8'd0;
      end else if (s4_ff.alpha_full) begin
         s5_in.alpha = 8'hFF;
      end else begin
         s5_in.alpha = s4_ff.prod[brob_pkg::ALPHA_SHIFT+7:brob_pkg::ALPHA_SHIFT];
      end
   end

   always_comb begin
      logic [7:0] src_r, src_g, src_b;
      logic [7:0] dst_r, dst_g, dst_b;
      logic [7:0] inv;
      src_r = {alert_color_ff[15:11], alert_color_ff[15:13]};
      src_g = {alert_color_ff[10:5],  alert_color_ff[10:9]};
      src_b = {alert_color_ff[4:0],   alert_color_ff[4:2]};
      dst_r = {s5_ff.under[15:11], s5_ff.under[15:13]};
      dst_g = {s5_ff.under[10:5],  s5_ff.under[10:9]};
      dst_b = {s5_ff.under[4:0],   s5_ff.under[4:2]};
      inv   = 8'hFF - s5_ff.alpha;
      s6_in.sum_r = ({8'd0, src_r} * {8'd0, s5_ff.alpha})
                  + ({8'd0, dst_r} * {8'd0, inv}) + 16'd127;
      s6_in.sum_g = ({8'd0, src_g} * {8'd0, s5_ff.alpha})
                  + ({8'd0, dst_g} * {8'd0, inv}) + 16'd127;
      s6_in.sum_b = ({8'd0, src_b} * {8'd0, s5_ff.alpha})
                  + ({8'd0, dst_b} * {8'd0, inv}) + 16'd127;
      s6_in.ring  = s5_ff.ring;
      s6_in.alpha = s5_ff.alpha;
      s6_in.under = s5_ff.under;
   end

   always_comb begin
      logic [15:0] tr, tg, tb;
      tr = s6_ff.sum_r + 16'd1 + {8'd0, s6_ff.sum_r[15:8]};
      tg = s6_ff.sum_g + 16'd1 + {8'd0, s6_ff.sum_g[15:8]};
      tb = s6_ff.sum_b + 16'd1 + {8'd0, s6_ff.sum_b[15:8]};
      s7_in.in_ring    = s6_ff.ring;
      s7_in.ring_alpha = s6_ff.alpha;
      if (!active || !s6_ff.ring || (s6_ff.alpha == 8'd0)) begin
         s7_in.out_pixel = s6_ff.under;
      end else if (s6_ff.alpha == 8'hFF) begin
         s7_in.out_pixel = alert_color_ff;
      end else begin
         s7_in.out_pixel = {tr[15:11], tg[15:10], tb[15:11]};
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) s1_ff <= s1_in;
      if (rdy[1]) s2_ff <= s2_in;
      if (rdy[2]) s3_ff <= s3_in;
      if (rdy[3]) s4_ff <= s4_in;
      if (rdy[4]) s5_ff <= s5_in;
      if (rdy[5]) s6_ff <= s6_in;
      if (rdy[6]) s7_ff <= s7_in;
   end

endmodule

// ===== hdl/brob_checker.sv =====
// Port-level checker for the breathing ring overlay blend unit, with its bind.
`timescale 1ns / 1ps
`include "breathing_ring_overlay_blend_unit_macros.svh"

module brob_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input brob_pkg::rsp_payload_type        rsp_payload,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic [brob_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [15:0]                      csr_wdata
);

   logic [15:0] color_ff, color_in;
   logic        enable_ff, enable_in;

   always_comb begin
      color_in  = color_ff;
      enable_in = enable_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            brob_pkg::CSR_ALERT_COLOR: color_in  = csr_wdata;
            brob_pkg::CSR_RING_ACTIVE: enable_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff  <= 16'd0;
         enable_ff <= 1'b0;
      end else begin
         color_ff  <= color_in;
         enable_ff <= enable_in;
      end
   end

   `BROB_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid, "valid after reset")
   `BROB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled transaction changed")
   `BROB_ASSERT_NOW(a_opaque_color, clock, reset, rsp_valid && rsp_payload.in_ring && (rsp_payload.ring_alpha == 8'hFF), rsp_payload.out_pixel == color_ff, "opaque ring pixel not alert color")
   `BROB_ASSERT_NOW(a_alpha_active, clock, reset, rsp_valid && (rsp_payload.ring_alpha != 8'd0), enable_ff && (color_ff != 16'd0), "alpha while ring inactive")

endmodule

bind breathing_ring_overlay_blend_unit brob_checker u_brob_checker (.*);
